### rtl/core/psrc_pkg.sv
`default_nettype none

package psrc_pkg;

   localparam int NUM_SLOTS_DEF   = 40;
   localparam int COORD_BITS_DEF  = 16;
   localparam int SLOT_BITS       = 6;
   localparam int IDX_BITS        = 8;   // enough for the largest ring
   localparam int HALF_BITS       = 8;
   localparam logic [HALF_BITS-1:0] HALF_SIZE_RESET = 8'd24;

   localparam logic FUNC_PLACE  = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // control part of the token that walks the chain
   typedef struct packed {
      logic valid;
      logic func;
      logic hit;     // place: some cell so far holds a square around the point
      logic match;   // remove: the named cell holds exactly the point
   } tok_ctl_type;

   // state update broadcast at the end of a sweep
   typedef struct packed {
      logic                wr;
      logic                clr;
      logic [IDX_BITS-1:0] slot;
   } commit_type;

endpackage

`default_nettype wire

### rtl/core/proximity_suppression_ring_cache.sv
`default_nettype none

// Ring cache of NUM_SLOTS remembered points that drops points landing near
// one already stored. Each slot is a cell in a chain; an accepted item walks
// the chain one cell per clock, every cell testing the point against its own
// entry (square of half edge csr_data-set half_size, low edge inclusive, high
// edge exclusive) and, for a remove, checking whether it is the named slot
// holding exactly that point. When the item leaves the last cell the state
// is updated at once: a place miss writes the slot at the round-robin
// pointer (overwriting a full ring) and returns that slot; a remove match
// clears the slot. One result item per request. An item's time from
// acceptance to its result is set by the length of the cell chain.
// The next item can be taken the cycle after its predecessor leaves the
// chain, since the state update lands at that edge and the first cell must
// see it, so the block takes no new item while one is still in the chain.
// The result sits in an output register with one spare entry behind it, so
// a stalled result channel holds back new items only once both are full.
// half_size resets to 24 and may be written only while the block is idle;
// the store resets empty with no clearing pass.

module proximity_suppression_ring_cache #(
   parameter int NUM_SLOTS  = psrc_pkg::NUM_SLOTS_DEF,
   parameter int COORD_BITS = psrc_pkg::COORD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_func,
   input  wire logic signed [COORD_BITS-1:0]      req_point_x,
   input  wire logic signed [COORD_BITS-1:0]      req_point_y,
   input  wire logic [psrc_pkg::SLOT_BITS-1:0]    req_slot_in,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_hit,
   output logic [psrc_pkg::SLOT_BITS-1:0]         rsp_slot_out,
   output logic                                   rsp_removed,

   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [psrc_pkg::HALF_BITS-1:0]    csr_data
);
   import psrc_pkg::*;

   logic [HALF_BITS-1:0] half_size_ff;

   // chain links: link k feeds cell k, link NUM_SLOTS is the chain exit
   tok_ctl_type                  link_ctl  [NUM_SLOTS+1];
   logic signed [COORD_BITS-1:0] link_x    [NUM_SLOTS+1];
   logic signed [COORD_BITS-1:0] link_y    [NUM_SLOTS+1];
   logic [SLOT_BITS-1:0]         link_slot [NUM_SLOTS+1];

   logic       launch;
   commit_type commit;

   // config register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_size_ff <= HALF_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         half_size_ff <= csr_data;
      end
   end

   // new token enters the first cell straight from the request port
   assign link_ctl[0]  = tok_ctl_type'{valid: launch, func: req_func,
                                       hit: 1'b0, match: 1'b0};
   assign link_x[0]    = req_point_x;
   assign link_y[0]    = req_point_y;
   assign link_slot[0] = req_slot_in;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      psrc_cell #(
         .COORD_BITS (COORD_BITS),
         .IDX        (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_i      (link_ctl[i]),
         .tok_x_i    (link_x[i]),
         .tok_y_i    (link_y[i]),
         .tok_slot_i (link_slot[i]),
         .half_size  (half_size_ff),
         .commit_i   (commit),
         // a write stores the point carried out of the chain end
         .commit_x   (link_x[NUM_SLOTS]),
         .commit_y   (link_y[NUM_SLOTS]),
         .tok_o      (link_ctl[i+1]),
         .tok_x_o    (link_x[i+1]),
         .tok_y_o    (link_y[i+1]),
         .tok_slot_o (link_slot[i+1])
      );
   end

   psrc_ctrl #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .launch       (launch),
      .exit_tok     (link_ctl[NUM_SLOTS]),
      .exit_slot    (link_slot[NUM_SLOTS]),
      .commit_o     (commit),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit),
      .rsp_slot_out (rsp_slot_out),
      .rsp_removed  (rsp_removed)
   );

endmodule

`default_nettype wire

### rtl/core/psrc_cell.sv
`default_nettype none

module psrc_cell #(
   parameter int COORD_BITS = 16,
   parameter int IDX        = 0
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire psrc_pkg::tok_ctl_type               tok_i,
   input  wire logic signed [COORD_BITS-1:0]        tok_x_i,
   input  wire logic signed [COORD_BITS-1:0]        tok_y_i,
   input  wire logic [psrc_pkg::SLOT_BITS-1:0]      tok_slot_i,
   input  wire logic [psrc_pkg::HALF_BITS-1:0]      half_size,
   input  wire psrc_pkg::commit_type                commit_i,
   input  wire logic signed [COORD_BITS-1:0]        commit_x,
   input  wire logic signed [COORD_BITS-1:0]        commit_y,
   output psrc_pkg::tok_ctl_type                    tok_o,
   output logic signed [COORD_BITS-1:0]             tok_x_o,
   output logic signed [COORD_BITS-1:0]             tok_y_o,
   output logic [psrc_pkg::SLOT_BITS-1:0]           tok_slot_o
);
   import psrc_pkg::*;

   localparam int EW = COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] entry_x_ff, entry_y_ff;
   logic                         entry_valid_ff, entry_valid_in;
   tok_ctl_type                  tok_ff, tok_in;
   logic signed [COORD_BITS-1:0] tok_x_ff, tok_y_ff;
   logic [SLOT_BITS-1:0]         tok_slot_ff;

   logic signed [EW-1:0] px_e, py_e, ex_e, ey_e, h_e;
   logic                 in_square, my_hit, my_match, mine_commit;

   always_comb begin
      px_e = EW'(tok_x_i);
      py_e = EW'(tok_y_i);
      ex_e = EW'(entry_x_ff);
      ey_e = EW'(entry_y_ff);
      h_e  = EW'($signed({1'b0, half_size}));
      // low edge inclusive, high edge exclusive, full precision
      in_square = (px_e >= ex_e - h_e) && (px_e < ex_e + h_e) &&
                  (py_e >= ey_e - h_e) && (py_e < ey_e + h_e);
      my_hit   = entry_valid_ff && in_square;
      my_match = entry_valid_ff && (IDX_BITS'(tok_slot_i) == IDX_BITS'(IDX)) &&
                 (tok_x_i == entry_x_ff) && (tok_y_i == entry_y_ff);

      tok_in       = tok_i;
      tok_in.hit   = tok_i.hit   | ((tok_i.func == FUNC_PLACE)  & my_hit);
      tok_in.match = tok_i.match | ((tok_i.func == FUNC_REMOVE) & my_match);

      mine_commit    = (commit_i.slot == IDX_BITS'(IDX));
      entry_valid_in = entry_valid_ff;
      if (mine_commit && commit_i.wr) begin
         entry_valid_in = 1'b1;
      end else if (mine_commit && commit_i.clr) begin
         entry_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         tok_ff         <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         tok_ff         <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mine_commit && commit_i.wr) begin
         entry_x_ff <= commit_x;
         entry_y_ff <= commit_y;
      end
      tok_x_ff    <= tok_x_i;
      tok_y_ff    <= tok_y_i;
      tok_slot_ff <= tok_slot_i;
   end

   assign tok_o      = tok_ff;
   assign tok_x_o    = tok_x_ff;
   assign tok_y_o    = tok_y_ff;
   assign tok_slot_o = tok_slot_ff;

endmodule

`default_nettype wire

### rtl/core/psrc_ctrl.sv
`default_nettype none

module psrc_ctrl #(
   parameter int NUM_SLOTS = 40
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   output logic                                launch,
   input  wire psrc_pkg::tok_ctl_type          exit_tok,
   input  wire logic [psrc_pkg::SLOT_BITS-1:0] exit_slot,
   output psrc_pkg::commit_type                commit_o,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_hit,
   output logic [psrc_pkg::SLOT_BITS-1:0]      rsp_slot_out,
   output logic                                rsp_removed
);
   import psrc_pkg::*;

   localparam int PTR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(NUM_SLOTS - 1);

   logic             busy_ff, busy_in;
   logic [PTR_W-1:0] next_slot_ff, next_slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_hit_ff, rsp_removed_ff, pend_hit_ff, pend_removed_ff;
   logic [SLOT_BITS-1:0] rsp_slot_ff, pend_slot_ff;

   logic                 done, take, out_free;
   logic                 res_hit, res_removed;
   logic [SLOT_BITS-1:0] res_slot;

   always_comb begin
      done     = exit_tok.valid;
      take     = rsp_valid_ff & ~rsp_stall;
      out_free = ~rsp_valid_ff | take;

      res_hit     = (exit_tok.func == FUNC_PLACE) & exit_tok.hit;
      res_removed = (exit_tok.func == FUNC_REMOVE) & exit_tok.match;
      res_slot    = '0;
      if ((exit_tok.func == FUNC_PLACE) && !exit_tok.hit) begin
         res_slot = SLOT_BITS'(next_slot_ff);
      end

      commit_o.wr   = done & (exit_tok.func == FUNC_PLACE) & ~exit_tok.hit;
      commit_o.clr  = done & res_removed;
      commit_o.slot = commit_o.wr ? IDX_BITS'(next_slot_ff) : IDX_BITS'(exit_slot);

      next_slot_in = next_slot_ff;
      if (commit_o.wr) begin
         next_slot_in = (next_slot_ff == LAST_SLOT) ? '0 : next_slot_ff + 1'b1;
      end

      // the commit of a finishing sweep lands at the same edge a new item would
      // enter cell 0, so the chain is only reopened the cycle after
      req_stall = pend_valid_ff | busy_ff;
      launch    = req_valid & ~req_stall;
      busy_in   = launch | (busy_ff & ~done);

      rsp_valid_in  = rsp_valid_ff & ~take;
      pend_valid_in = pend_valid_ff;
      if (pend_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
      if (done) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
         end else begin
            pend_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         next_slot_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         next_slot_ff  <= next_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_valid_ff && out_free) begin
         rsp_hit_ff     <= pend_hit_ff;
         rsp_slot_ff    <= pend_slot_ff;
         rsp_removed_ff <= pend_removed_ff;
      end else if (done && out_free) begin
         rsp_hit_ff     <= res_hit;
         rsp_slot_ff    <= res_slot;
         rsp_removed_ff <= res_removed;
      end
      if (done && !out_free) begin
         pend_hit_ff     <= res_hit;
         pend_slot_ff    <= res_slot;
         pend_removed_ff <= res_removed;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_removed  = rsp_removed_ff;

endmodule

`default_nettype wire

### tb/sv/psrc_checker.sv
module ring_cache_checker (
   input  wire logic                                        clock,
   input  wire logic                                        reset,

   input  wire logic                                        req_valid,
   input  wire logic                                        req_stall,
   input  wire logic                                        req_func,
   input  wire logic signed [psrc_pkg::COORD_BITS_DEF-1:0]  req_point_x,
   input  wire logic signed [psrc_pkg::COORD_BITS_DEF-1:0]  req_point_y,
   input  wire logic [psrc_pkg::SLOT_BITS-1:0]              req_slot_in,

   input  wire logic                                        rsp_valid,
   input  wire logic                                        rsp_stall,
   input  wire logic                                        rsp_hit,
   input  wire logic [psrc_pkg::SLOT_BITS-1:0]              rsp_slot_out,
   input  wire logic                                        rsp_removed,

   input  wire logic                                        csr_valid,
   input  wire logic                                        csr_ready,
   input  wire logic [psrc_pkg::HALF_BITS-1:0]              csr_data,

   output int                                               fail_count,
   output int                                               answers_pending
);
   import psrc_pkg::*;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
      logic                 removed;
   } answer_type;

   logic signed [COORD_BITS_DEF-1:0] kept_x [NUM_SLOTS_DEF];
   logic signed [COORD_BITS_DEF-1:0] kept_y [NUM_SLOTS_DEF];
   logic                             kept_used [NUM_SLOTS_DEF];
   int                               write_ptr;
   logic [HALF_BITS-1:0]             half_edge;
   answer_type                       answers_due [$];

   initial begin
      fail_count      = 0;
      answers_pending = 0;
   end

   // place: square test against every live entry, store on a miss
   // remove: clear the named slot only on an exact point match
   function automatic answer_type resolve_request(input logic func,
                                                  input logic signed [COORD_BITS_DEF-1:0] px,
                                                  input logic signed [COORD_BITS_DEF-1:0] py,
                                                  input logic [SLOT_BITS-1:0] slot);
      answer_type a;
      int         h;
      a = '0;
      h = int'(half_edge);
      if (func == FUNC_PLACE) begin
         for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
            if (kept_used[i] &&
                int'(px) >= int'(kept_x[i]) - h && int'(px) < int'(kept_x[i]) + h &&
                int'(py) >= int'(kept_y[i]) - h && int'(py) < int'(kept_y[i]) + h)
               a.hit = 1'b1;
         end
         if (!a.hit) begin
            kept_x[write_ptr]    = px;
            kept_y[write_ptr]    = py;
            kept_used[write_ptr] = 1'b1;
            a.slot               = SLOT_BITS'(write_ptr);
            write_ptr            = (write_ptr + 1 >= NUM_SLOTS_DEF) ? 0 : write_ptr + 1;
         end
      end else begin
         if (int'(slot) < NUM_SLOTS_DEF && kept_used[slot] &&
             kept_x[slot] == px && kept_y[slot] == py) begin
            kept_x[slot]    = '0;
            kept_y[slot]    = '0;
            kept_used[slot] = 1'b0;
            a.removed       = 1'b1;
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
            kept_x[i]    = '0;
            kept_y[i]    = '0;
            kept_used[i] = 1'b0;
         end
         write_ptr = 0;
         half_edge = HALF_SIZE_RESET;
         answers_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            half_edge = csr_data;

         // result first: it always belongs to an older item
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("result item with no expectation waiting");
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_slot_out !== want.slot) begin
                  $error("slot_out: expected %0d, got %0d", want.slot, rsp_slot_out);
                  fail_count++;
               end
               if (rsp_removed !== want.removed) begin
                  $error("removed: expected %0d, got %0d", want.removed, rsp_removed);
                  fail_count++;
               end
            end
         end

         if (req_valid && !req_stall)
            answers_due.push_back(resolve_request(req_func, req_point_x, req_point_y,
                                                  req_slot_in));
      end
      answers_pending = answers_due.size();
   end

endmodule

### tb/sv/tb.sv
module tb;
   import psrc_pkg::*;

   localparam int NPHASE    = 8;
   localparam int PER_PHASE = 137;
   localparam int HOLD_LEN  = 300;

   logic                             clock;
   logic                             reset;

   logic                             req_valid;
   logic                             req_stall;
   logic                             req_func;
   logic signed [COORD_BITS_DEF-1:0] req_point_x;
   logic signed [COORD_BITS_DEF-1:0] req_point_y;
   logic [SLOT_BITS-1:0]             req_slot_in;

   logic                             rsp_valid;
   logic                             rsp_stall;
   logic                             rsp_hit;
   logic [SLOT_BITS-1:0]             rsp_slot_out;
   logic                             rsp_removed;

   logic                             csr_valid;
   logic                             csr_ready;
   logic [HALF_BITS-1:0]             csr_data;

   int                               fail_count;
   int                               answers_pending;

   // stimulus knobs shared by sender and receiver
   logic                             calm;       // no idling on either side
   logic                             hold_req;   // asks for the long receiver hold
   logic                             hold_on;
   int                               cur_half;

   // points last seen stored per slot, so removes can aim at live entries
   typedef struct {
      logic func;
      int   x;
      int   y;
   } sent_type;
   sent_type sent_q [$];
   int    seen_x [64];
   int    seen_y [64];
   int    ctr_x [4];
   int    ctr_y [4];

   proximity_suppression_ring_cache u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_slot_in  (req_slot_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit),
      .rsp_slot_out (rsp_slot_out),
      .rsp_removed  (rsp_removed),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   ring_cache_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_slot_in     (req_slot_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_removed     (rsp_removed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .answers_pending (answers_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop; the slowest legal run is well under a fifth of this
   initial begin
      #2000000;
      $display("[proximity_suppression_ring_cache] ERROR");
      $finish;
   end

   // Offer one item after a random gap. Called at a falling edge, returns at
   // the falling edge after acceptance with valid still high, so a zero gap
   // keeps valid up with a single assignment in that step.
   task automatic send_item(input logic func, input int x, input int y, input int slot);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_point_x <= COORD_BITS_DEF'(x);
      req_point_y <= COORD_BITS_DEF'(y);
      req_slot_in <= SLOT_BITS'(slot);
      do @(posedge clock); while (req_stall);
      sent_q.push_back('{func, int'(signed'(COORD_BITS_DEF'(x))),
                         int'(signed'(COORD_BITS_DEF'(y)))});
      @(negedge clock);
   endtask

   // drop valid and let every outstanding result come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (answers_pending != 0) @(negedge clock);
   endtask

   task automatic write_half(input int v);
      csr_valid <= 1'b1;
      csr_data  <= HALF_BITS'(v);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_half  = v;
   endtask

   function automatic int rim_coord();
      case ($urandom_range(0, 3))
         0:       return -32768;
         1:       return -32767;
         2:       return 32766;
         default: return 32767;
      endcase
   endfunction

   // signed offset within +-span
   function automatic int jitter(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly well-formed traffic: places clustered around a few centers so
   // squares collide, removes aimed at points known to sit in a slot; the
   // rest is rim values, full-range noise and near-miss removes.
   task automatic random_item();
      int roll, pick, span, c, x, y, slot;
      logic func;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      span = 2 * cur_half + 3;
      slot = $urandom_range(0, 63);
      if (roll < 65) begin
         func = FUNC_PLACE;
         if (pick < 50) begin
            c = $urandom_range(0, 3);
            x = ctr_x[c] + jitter(span);
            y = ctr_y[c] + jitter(span);
         end else if (pick < 65) begin
            c = $urandom_range(0, NUM_SLOTS_DEF - 1);
            x = seen_x[c] + jitter(span);
            y = seen_y[c] + jitter(span);
         end else if (pick < 80) begin
            x = ($urandom_range(0, 1) != 0) ? rim_coord() : int'($urandom_range(0, 65535));
            y = ($urandom_range(0, 1) != 0) ? rim_coord() : int'($urandom_range(0, 65535));
         end else begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
         end
      end else begin
         func = FUNC_REMOVE;
         slot = (pick < 85) ? $urandom_range(0, NUM_SLOTS_DEF - 1)
                            : $urandom_range(NUM_SLOTS_DEF, 63);
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            x = seen_x[slot];
            y = seen_y[slot];
         end else if (pick < 88) begin
            x = seen_x[slot] + int'($urandom_range(0, 1)) * 2 - 1;
            y = seen_y[slot];
         end else begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
         end
      end
      send_item(func, x, y, slot);
   endtask

   // Receiver: a fresh stall count after every accepted result, plus the
   // long hold when it is running.
   initial begin : receiver
      int       stall_left;
      sent_type rec;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (sent_q.size() != 0) begin
               rec = sent_q.pop_front();
               if (rec.func == FUNC_PLACE && !rsp_hit) begin
                  seen_x[rsp_slot_out] = rec.x;
                  seen_y[rsp_slot_out] = rec.y;
               end
            end
            stall_left = calm ? 0 : $urandom_range(0, 13);
         end
         @(negedge clock);
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Long hold on the result side while the sender keeps offering: output
   // register and spare fill up, then the block must stall its input.
   initial begin : long_hold
      hold_on = 1'b0;
      wait (hold_req);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_on = 1'b0;
   end

   initial begin : stimulus
      int phase_half [NPHASE];
      req_valid   = 1'b0;
      req_func    = FUNC_PLACE;
      req_point_x = '0;
      req_point_y = '0;
      req_slot_in = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      calm        = 1'b0;
      hold_req    = 1'b0;
      cur_half    = int'(HALF_SIZE_RESET);
      for (int i = 0; i < 64; i++) begin
         seen_x[i] = 0;
         seen_y[i] = 0;
      end
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, at the reset half size of 24, ring empty
      send_item(FUNC_PLACE,       0,      0,  0);   // miss, slot 0
      send_item(FUNC_PLACE,       0,      0,  0);   // same point hits
      send_item(FUNC_PLACE,     -24,    -24, 17);   // low corner inclusive
      send_item(FUNC_PLACE,      23,     23, 63);   // just inside high edge
      send_item(FUNC_PLACE,      24,      0,  0);   // high x edge exclusive
      send_item(FUNC_PLACE,       0,     24,  0);   // high y edge exclusive
      send_item(FUNC_PLACE,     -25,      0,  0);   // just below low edge
      send_item(FUNC_PLACE,   32767,  32767,  0);   // square past the top
      send_item(FUNC_PLACE,   32767,  32767,  0);
      send_item(FUNC_PLACE,  -32768, -32768,  0);   // no wrap to the top corner
      send_item(FUNC_PLACE,  -32768, -32768,  0);
      send_item(FUNC_PLACE,   32767, -32768,  0);
      send_item(FUNC_REMOVE,      0,      0,  0);   // exact match clears
      send_item(FUNC_REMOVE,      0,      0,  0);   // now empty
      send_item(FUNC_REMOVE,      0,      0, 20);   // never written, point (0,0)
      send_item(FUNC_REMOVE,      0,      0, 40);   // past the ring
      send_item(FUNC_REMOVE,     -1,     -1, 63);
      send_item(FUNC_REMOVE,     24,      1,  1);   // wrong point
      send_item(FUNC_REMOVE,     24,      0,  1);
      send_item(FUNC_PLACE,       0,      0, 63);   // cleared slot 0 misses, slot 2 (0,24) still hits
      send_item(FUNC_PLACE,      -1,     -1,  5);

      // half-size settings, extremes included; 0 means nothing can hit
      phase_half[0] = 0;
      phase_half[1] = 255;
      phase_half[2] = 1;
      phase_half[3] = 24;
      phase_half[4] = $urandom_range(2, 254);
      phase_half[5] = 255;
      phase_half[6] = $urandom_range(2, 254);
      phase_half[7] = 2;

      for (int p = 0; p < NPHASE; p++) begin
         wait_drained();
         write_half(phase_half[p]);
         calm = (p == 3 || p == 6);
         for (int c = 0; c < 4; c++) begin
            ctr_x[c] = $urandom_range(0, 65535);
            ctr_y[c] = $urandom_range(0, 65535);
         end
         ctr_x[3] = rim_coord();   // one cluster hugs the coordinate rim
         for (int k = 0; k < PER_PHASE; k++) begin
            if (p == 1 && k == 20)
               hold_req = 1'b1;
            random_item();
         end
      end

      wait_drained();
      repeat (NUM_SLOTS_DEF + 8) @(posedge clock);
      if (fail_count == 0 && answers_pending == 0) begin
         $display("[proximity_suppression_ring_cache] OK");
      end else begin
         $display("[proximity_suppression_ring_cache] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/psrc_pkg.sv
rtl/core/psrc_cell.sv
rtl/core/psrc_ctrl.sv
rtl/core/proximity_suppression_ring_cache.sv
tb/sv/psrc_checker.sv
tb/sv/tb.sv
